>>> rtl/core/assert_macros.svh
// Assertion helpers. All properties are sampled on clk and disabled during reset.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

`define TLPE_ASSERT(label, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("assertion failed");

`define TLPE_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

`else

`define TLPE_ASSERT(label, prop)

`define TLPE_ASSERT_NEXT(label, ante, cons)

`endif

`endif

>>> rtl/core/tlpe_pkg.sv
package tlpe_pkg;

    localparam int DUR_W  = 16;
    localparam int ADDR_W = 5;
    localparam int DATA_W = 32;

    typedef logic [DUR_W-1:0] dur_t;

    typedef struct packed {
        dur_t green_ms;
        dur_t yellow_ms;
        dur_t red_ms;
        dur_t blink_ms;
        dur_t debounce_ms;
    } cfg_t;

    typedef struct packed {
        logic red;
        logic yellow;
        logic green;
        logic emergency;
    } lamps_t;

    typedef enum logic [2:0] {
        REG_GREEN    = 3'd0,
        REG_YELLOW   = 3'd1,
        REG_RED      = 3'd2,
        REG_BLINK    = 3'd3,
        REG_DEBOUNCE = 3'd4
    } reg_idx_t;

    localparam dur_t RST_GREEN_MS    = 16'd5000;
    localparam dur_t RST_YELLOW_MS   = 16'd2000;
    localparam dur_t RST_RED_MS      = 16'd5000;
    localparam dur_t RST_BLINK_MS    = 16'd500;
    localparam dur_t RST_DEBOUNCE_MS = 16'd400;

endpackage

>>> rtl/core/tlpe_regs.sv
module tlpe_regs
(
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [tlpe_pkg::ADDR_W-1:0] paddr,
    input  logic [tlpe_pkg::DATA_W-1:0] pwdata,
    output logic [tlpe_pkg::DATA_W-1:0] prdata,
    output logic                        pready,
    output tlpe_pkg::cfg_t              cfg
);
    import tlpe_pkg::*;

    cfg_t     cfg_reg;
    cfg_t     cfg_next;
    reg_idx_t idx;
    dur_t     wdata;
    dur_t     rdata;
    logic     wr_en;

    assign idx    = reg_idx_t'(paddr[ADDR_W-1:2]);
    assign wdata  = pwdata[DUR_W-1:0];
    assign wr_en  = psel && penable && pwrite;
    assign pready = 1'b1;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (wr_en)
        begin
            unique case (idx)
                REG_GREEN:    cfg_next.green_ms    = wdata;
                REG_YELLOW:   cfg_next.yellow_ms   = wdata;
                REG_RED:      cfg_next.red_ms      = wdata;
                REG_BLINK:    cfg_next.blink_ms    = wdata;
                REG_DEBOUNCE: cfg_next.debounce_ms = wdata;
                default:      ;
            endcase
        end
    end

    always_comb
    begin
        unique case (idx)
            REG_GREEN:    rdata = cfg_reg.green_ms;
            REG_YELLOW:   rdata = cfg_reg.yellow_ms;
            REG_RED:      rdata = cfg_reg.red_ms;
            REG_BLINK:    rdata = cfg_reg.blink_ms;
            REG_DEBOUNCE: rdata = cfg_reg.debounce_ms;
            default:      rdata = '0;
        endcase
    end

    assign prdata = {{(DATA_W-DUR_W){1'b0}}, rdata};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.green_ms    <= RST_GREEN_MS;
            cfg_reg.yellow_ms   <= RST_YELLOW_MS;
            cfg_reg.red_ms      <= RST_RED_MS;
            cfg_reg.blink_ms    <= RST_BLINK_MS;
            cfg_reg.debounce_ms <= RST_DEBOUNCE_MS;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule

>>> rtl/core/tlpe_debounce.sv
`include "assert_macros.svh"

module tlpe_debounce
#(
    parameter int COUNT_WIDTH = 16
)
(
    input  logic           clk,
    input  logic           rst_n,
    input  logic           step,
    input  logic           press,
    input  tlpe_pkg::dur_t debounce_ms,
    output logic           accepted
);
    import tlpe_pkg::*;

    localparam int CMP_W = (COUNT_WIDTH > DUR_W) ? COUNT_WIDTH : DUR_W;

    logic [COUNT_WIDTH-1:0] quiet_reg;
    logic [COUNT_WIDTH-1:0] quiet_next;
    logic [COUNT_WIDTH-1:0] quiet_inc;

    // The quiet counter saturates at all ones.
    assign quiet_inc = (&quiet_reg) ? quiet_reg : quiet_reg + 1'b1;
    assign accepted  = press && (CMP_W'(quiet_inc) > CMP_W'(debounce_ms));

    always_comb
    begin
        quiet_next = quiet_reg;
        if (step)
        begin
            quiet_next = accepted ? '0 : quiet_inc;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            quiet_reg <= '0;
        end
        else
        begin
            quiet_reg <= quiet_next;
        end
    end

    `TLPE_ASSERT_NEXT(a_press_clears_quiet, step && accepted, quiet_reg == '0)

endmodule

>>> rtl/core/tlpe_phase_fsm.sv
`include "assert_macros.svh"

module tlpe_phase_fsm
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             step,
    input  logic             emerg_acc,
    input  logic             ped_acc,
    input  tlpe_pkg::cfg_t   cfg,
    output tlpe_pkg::lamps_t lamps
);
    import tlpe_pkg::*;

    typedef enum logic [1:0] {
        PH_GREEN  = 2'd0,
        PH_YELLOW = 2'd1,
        PH_RED    = 2'd2,
        PH_EMERG  = 2'd3
    } phase_t;

    phase_t phase_reg;
    phase_t phase_next;
    dur_t   phase_cnt_reg;
    dur_t   phase_cnt_next;
    dur_t   blink_cnt_reg;
    dur_t   blink_cnt_next;
    logic   blink_lvl_reg;
    logic   blink_lvl_next;
    lamps_t lamps_reg;
    lamps_t lamps_next;
    logic   loaded;

    always_comb
    begin
        phase_next     = phase_reg;
        phase_cnt_next = phase_cnt_reg;
        blink_cnt_next = blink_cnt_reg;
        blink_lvl_next = blink_lvl_reg;
        loaded         = 1'b0;

        // An emergency request toggles emergency mode; leaving it restarts red.
        if (emerg_acc)
        begin
            if (phase_reg != PH_EMERG)
            begin
                phase_next     = PH_EMERG;
                blink_lvl_next = 1'b0;
                blink_cnt_next = cfg.blink_ms;
            end
            else
            begin
                phase_next     = PH_RED;
                phase_cnt_next = cfg.red_ms;
            end
            loaded = 1'b1;
        end

        if (ped_acc && (phase_next == PH_GREEN))
        begin
            phase_next     = PH_YELLOW;
            phase_cnt_next = cfg.yellow_ms;
            loaded         = 1'b1;
        end

        if (!loaded)
        begin
            if (phase_reg == PH_EMERG)
            begin
                if (blink_cnt_reg <= 16'd1)
                begin
                    blink_lvl_next = !blink_lvl_reg;
                    blink_cnt_next = cfg.blink_ms;
                end
                else
                begin
                    blink_cnt_next = blink_cnt_reg - 1'b1;
                end
            end
            else if (phase_cnt_reg <= 16'd1)
            begin
                unique case (phase_reg)
                    PH_GREEN:
                    begin
                        phase_next     = PH_YELLOW;
                        phase_cnt_next = cfg.yellow_ms;
                    end
                    PH_YELLOW:
                    begin
                        phase_next     = PH_RED;
                        phase_cnt_next = cfg.red_ms;
                    end
                    default:
                    begin
                        phase_next     = PH_GREEN;
                        phase_cnt_next = cfg.green_ms;
                    end
                endcase
            end
            else
            begin
                phase_cnt_next = phase_cnt_reg - 1'b1;
            end
        end

        lamps_next.red       = (phase_next == PH_RED);
        lamps_next.yellow    = (phase_next == PH_YELLOW) ||
                               ((phase_next == PH_EMERG) && blink_lvl_next);
        lamps_next.green     = (phase_next == PH_GREEN);
        lamps_next.emergency = (phase_next == PH_EMERG);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg      <= PH_GREEN;
            phase_cnt_reg  <= RST_GREEN_MS;
            blink_cnt_reg  <= '0;
            blink_lvl_reg  <= 1'b0;
            lamps_reg      <= '{red: 1'b0, yellow: 1'b0, green: 1'b1, emergency: 1'b0};
        end
        else if (step)
        begin
            phase_reg      <= phase_next;
            phase_cnt_reg  <= phase_cnt_next;
            blink_cnt_reg  <= blink_cnt_next;
            blink_lvl_reg  <= blink_lvl_next;
            lamps_reg      <= lamps_next;
        end
    end

    assign lamps = lamps_reg;

    `TLPE_ASSERT(a_one_lamp_in_cycle,
        !lamps_reg.emergency |-> $onehot({lamps_reg.red, lamps_reg.yellow, lamps_reg.green}))

endmodule

>>> rtl/core/traffic_light_pedestrian_emergency_core.sv
// Path: an accepted request is captured in the input register and then moves into the result register.
// Throughput: one request per clock while out_stall is low; a new request is taken while an
// earlier result waits to be taken only if the input register is empty.
// Reset: rst_n is asynchronous, active low; lights restart in green with the
// configuration registers at their default durations.
`include "assert_macros.svh"

module traffic_light_pedestrian_emergency_core
#(
    parameter int COUNT_WIDTH = 16
)
(
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        in_valid,
    output logic                        in_stall,
    input  logic                        ped_press,
    input  logic                        emerg_press,
    output logic                        out_valid,
    input  logic                        out_stall,
    output logic                        red_light,
    output logic                        yellow_light,
    output logic                        green_light,
    output logic                        emergency_active,
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [tlpe_pkg::ADDR_W-1:0] paddr,
    input  logic [tlpe_pkg::DATA_W-1:0] pwdata,
    output logic [tlpe_pkg::DATA_W-1:0] prdata,
    output logic                        pready
);
    import tlpe_pkg::*;

    cfg_t   cfg;
    lamps_t lamps;
    logic   s1_valid_reg;
    logic   s1_valid_next;
    logic   ped_reg;
    logic   emerg_reg;
    logic   out_valid_reg;
    logic   out_valid_next;
    logic   step;
    logic   in_take;
    logic   ped_acc;
    logic   emerg_acc;

    // A buffered request moves into the result register when that register is free
    // or being emptied in the same cycle.
    assign step     = s1_valid_reg && (!out_valid_reg || !out_stall);
    assign in_stall = s1_valid_reg && !step;
    assign in_take  = in_valid && !in_stall;

    always_comb
    begin
        s1_valid_next = s1_valid_reg;
        if (in_take)
        begin
            s1_valid_next = 1'b1;
        end
        else if (step)
        begin
            s1_valid_next = 1'b0;
        end

        out_valid_next = out_valid_reg;
        if (step)
        begin
            out_valid_next = 1'b1;
        end
        else if (!out_stall)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg  <= s1_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_take)
        begin
            ped_reg   <= ped_press;
            emerg_reg <= emerg_press;
        end
    end

    tlpe_regs u_regs
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    tlpe_debounce #(.COUNT_WIDTH(COUNT_WIDTH)) u_ped_debounce
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .step        (step),
        .press       (ped_reg),
        .debounce_ms (cfg.debounce_ms),
        .accepted    (ped_acc)
    );

    tlpe_debounce #(.COUNT_WIDTH(COUNT_WIDTH)) u_emerg_debounce
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .step        (step),
        .press       (emerg_reg),
        .debounce_ms (cfg.debounce_ms),
        .accepted    (emerg_acc)
    );

    tlpe_phase_fsm u_phase_fsm
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .step      (step),
        .emerg_acc (emerg_acc),
        .ped_acc   (ped_acc),
        .cfg       (cfg),
        .lamps     (lamps)
    );

    assign out_valid        = out_valid_reg;
    assign red_light        = lamps.red;
    assign yellow_light     = lamps.yellow;
    assign green_light      = lamps.green;
    assign emergency_active = lamps.emergency;

    `TLPE_ASSERT_NEXT(a_buffered_request_delivered, s1_valid_reg && !out_valid_reg, out_valid_reg)
    `TLPE_ASSERT(a_stall_only_when_blocked, in_stall |-> (out_valid_reg && out_stall))

endmodule

>>> tb/sv/tb.sv
module tb;
    import tlpe_pkg::*;

    localparam int LATENCY          = 2;
    localparam int CYCLE_LIMIT      = 1000000;
    localparam int UNUSED_REG_FIRST = 5;
    localparam int UNUSED_REG_LAST  = 7;
    localparam int RANDOM_TICKS     = 230;
    localparam int LONG_TICKS       = 60;

    typedef enum logic [1:0] {
        PH_GREEN  = 2'd0,
        PH_YELLOW = 2'd1,
        PH_RED    = 2'd2,
        PH_EMERG  = 2'd3
    } light_phase_t;

    logic               clk         = 1'b0;
    logic               rst_n       = 1'b0;
    logic               in_valid    = 1'b0;
    logic               in_stall;
    logic               ped_press   = 1'b0;
    logic               emerg_press = 1'b0;
    logic               out_valid;
    logic               out_stall   = 1'b0;
    logic               red_light;
    logic               yellow_light;
    logic               green_light;
    logic               emergency_active;
    logic               psel        = 1'b0;
    logic               penable     = 1'b0;
    logic               pwrite      = 1'b0;
    logic [ADDR_W-1:0]  paddr       = '0;
    logic [DATA_W-1:0]  pwdata      = '0;
    logic [DATA_W-1:0]  prdata;
    logic               pready;

    int                 send_idle_pct = 0;
    int                 recv_idle_pct = 0;
    int                 mismatches    = 0;
    int                 cycles        = 0;

    cfg_t               dur_cfg;
    light_phase_t       phase_now;
    dur_t               phase_left;
    dur_t               blink_left;
    logic               blink_on;
    dur_t               ped_quiet;
    dur_t               emerg_quiet;
    lamps_t             lamps_due[$];

    traffic_light_pedestrian_emergency_core #(
        .COUNT_WIDTH(16)
    ) uut (
        .clk              (clk),
        .rst_n            (rst_n),
        .in_valid         (in_valid),
        .in_stall         (in_stall),
        .ped_press        (ped_press),
        .emerg_press      (emerg_press),
        .out_valid        (out_valid),
        .out_stall        (out_stall),
        .red_light        (red_light),
        .yellow_light     (yellow_light),
        .green_light      (green_light),
        .emergency_active (emergency_active),
        .psel             (psel),
        .penable          (penable),
        .pwrite           (pwrite),
        .paddr            (paddr),
        .pwdata           (pwdata),
        .prdata           (prdata),
        .pready           (pready)
    );

    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    function automatic void reset_lights();
        dur_cfg.green_ms    = RST_GREEN_MS;
        dur_cfg.yellow_ms   = RST_YELLOW_MS;
        dur_cfg.red_ms      = RST_RED_MS;
        dur_cfg.blink_ms    = RST_BLINK_MS;
        dur_cfg.debounce_ms = RST_DEBOUNCE_MS;
        phase_now   = PH_GREEN;
        phase_left  = RST_GREEN_MS;
        blink_left  = '0;
        blink_on    = 1'b0;
        ped_quiet   = '0;
        emerg_quiet = '0;
    endfunction

    function automatic void load_phase(light_phase_t p);
        phase_now = p;
        case (p)
            PH_GREEN:  phase_left = dur_cfg.green_ms;
            PH_YELLOW: phase_left = dur_cfg.yellow_ms;
            default:   phase_left = dur_cfg.red_ms;
        endcase
    endfunction

    function automatic lamps_t step_lights(logic ped, logic emerg);
        logic   loaded;
        lamps_t lamps;
        loaded = 1'b0;
        if (ped_quiet != '1)
            ped_quiet++;
        if (emerg_quiet != '1)
            emerg_quiet++;
        if (emerg && emerg_quiet > dur_cfg.debounce_ms)
        begin
            emerg_quiet = '0;
            if (phase_now != PH_EMERG)
            begin
                phase_now  = PH_EMERG;
                blink_on   = 1'b0;
                blink_left = dur_cfg.blink_ms;
            end
            else
            begin
                load_phase(PH_RED);
            end
            loaded = 1'b1;
        end
        if (ped && ped_quiet > dur_cfg.debounce_ms)
        begin
            ped_quiet = '0;
            if (phase_now == PH_GREEN)
            begin
                load_phase(PH_YELLOW);
                loaded = 1'b1;
            end
        end
        if (!loaded)
        begin
            if (phase_now == PH_EMERG)
            begin
                if (blink_left <= 1)
                begin
                    blink_on   = ~blink_on;
                    blink_left = dur_cfg.blink_ms;
                end
                else
                begin
                    blink_left--;
                end
            end
            else if (phase_left <= 1)
            begin
                case (phase_now)
                    PH_GREEN:  load_phase(PH_YELLOW);
                    PH_YELLOW: load_phase(PH_RED);
                    default:   load_phase(PH_GREEN);
                endcase
            end
            else
            begin
                phase_left--;
            end
        end
        lamps.red       = (phase_now == PH_RED);
        lamps.yellow    = (phase_now == PH_YELLOW) || (phase_now == PH_EMERG && blink_on);
        lamps.green     = (phase_now == PH_GREEN);
        lamps.emergency = (phase_now == PH_EMERG);
        return lamps;
    endfunction

    task automatic report_mismatch(input string what);
        $display("MISMATCH at cycle %0d: %s", cycles, what);
        mismatches++;
    endtask

    always @(posedge clk)
    begin : check_result
        lamps_t want;
        lamps_t got;
        if (rst_n && out_valid && !out_stall)
        begin
            got = {red_light, yellow_light, green_light, emergency_active};
            if (lamps_due.size() == 0)
            begin
                report_mismatch($sformatf("result %b with no request pending", got));
            end
            else
            begin
                want = lamps_due.pop_front();
                if (got.red !== want.red)
                    report_mismatch($sformatf("red_light %b, expected %b",
                                              got.red, want.red));
                if (got.yellow !== want.yellow)
                    report_mismatch($sformatf("yellow_light %b, expected %b",
                                              got.yellow, want.yellow));
                if (got.green !== want.green)
                    report_mismatch($sformatf("green_light %b, expected %b",
                                              got.green, want.green));
                if (got.emergency !== want.emergency)
                    report_mismatch($sformatf("emergency_active %b, expected %b",
                                              got.emergency, want.emergency));
            end
        end
    end

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles >= CYCLE_LIMIT)
        begin
            $display("Verification failed");
            $finish;
        end
    end

    always @(negedge clk)
    begin
        out_stall <= rst_n && ($urandom_range(99) < recv_idle_pct);
    end

    // A request is taken at the first rising edge at which in_stall is low.
    task automatic send_tick(input logic ped, input logic emerg);
        @(negedge clk);
        while ($urandom_range(99) < send_idle_pct)
        begin
            in_valid    = 1'b0;
            ped_press   = 1'($urandom_range(1));
            emerg_press = 1'($urandom_range(1));
            @(negedge clk);
        end
        in_valid    = 1'b1;
        ped_press   = ped;
        emerg_press = emerg;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        lamps_due.push_back(step_lights(ped, emerg));
    endtask

    task automatic wait_idle();
        @(negedge clk);
        in_valid = 1'b0;
        while (lamps_due.size() != 0)
            @(posedge clk);
        repeat (LATENCY + 2) @(posedge clk);
    endtask

    task automatic apb_write(input logic [ADDR_W-1:0] addr, input dur_t value);
        @(negedge clk);
        psel    = 1'b1;
        penable = 1'b0;
        pwrite  = 1'b1;
        paddr   = addr;
        pwdata  = {16'($urandom), value};
        @(negedge clk);
        penable = 1'b1;
        @(posedge clk);
        while (!pready)
            @(posedge clk);
        @(negedge clk);
        psel    = 1'b0;
        penable = 1'b0;
        pwrite  = 1'b0;
    endtask

    task automatic set_duration(input reg_idx_t idx, input dur_t value);
        apb_write({idx, 2'b00}, value);
        case (idx)
            REG_GREEN:    dur_cfg.green_ms    = value;
            REG_YELLOW:   dur_cfg.yellow_ms   = value;
            REG_RED:      dur_cfg.red_ms      = value;
            REG_BLINK:    dur_cfg.blink_ms    = value;
            REG_DEBOUNCE: dur_cfg.debounce_ms = value;
            default:      ;
        endcase
    endtask

    task automatic set_all(input dur_t g, input dur_t y, input dur_t r, input dur_t b,
                           input dur_t d);
        set_duration(REG_GREEN, g);
        set_duration(REG_YELLOW, y);
        set_duration(REG_RED, r);
        set_duration(REG_BLINK, b);
        set_duration(REG_DEBOUNCE, d);
    endtask

    // Presses right after reset fall inside the debounce window and are dropped.
    task automatic test_power_up_debounce();
        for (int i = 1; i <= 402; i++)
            send_tick(i <= 3 || i == 400 || i == 401, i <= 3 || i == 401);
    endtask

    task automatic test_directed_sequence();
        logic [1:0] script [25] = '{
            2'b00, 2'b01, 2'b01, 2'b00, 2'b00, 2'b00, 2'b00, 2'b10, 2'b00, 2'b00,
            2'b00, 2'b00, 2'b00, 2'b11, 2'b00, 2'b00, 2'b00, 2'b00, 2'b00, 2'b01,
            2'b00, 2'b00, 2'b00, 2'b00, 2'b11
        };
        wait_idle();
        set_all(16'd6, 16'd3, 16'd4, 16'd2, 16'd2);
        foreach (script[i])
            send_tick(script[i][0], script[i][1]);
    endtask

    task automatic test_zero_durations();
        wait_idle();
        set_all('0, '0, '0, '0, '0);
        repeat (40)
            send_tick($urandom_range(99) < 20, $urandom_range(99) < 10);
    endtask

    task automatic test_unused_registers();
        wait_idle();
        set_all(16'd3, 16'd2, 16'd3, 16'd1, 16'd1);
        for (int k = UNUSED_REG_FIRST; k <= UNUSED_REG_LAST; k++)
            apb_write({3'(k), 2'b00}, 16'($urandom));
        repeat (30)
            send_tick($urandom_range(99) < 25, $urandom_range(99) < 10);
    endtask

    // Full-width durations are loaded, and a debounce one below the maximum drops every press.
    task automatic test_long_durations();
        wait_idle();
        send_idle_pct = 0;
        recv_idle_pct = 0;
        set_all('1, '1, '1, '1, 16'd65534);
        for (int i = 0; i < LONG_TICKS; i++)
            send_tick((i % 7) == 3, (i % 11) == 5);
    endtask

    task automatic test_random_traffic(input int send_pct, input int recv_pct);
        wait_idle();
        send_idle_pct = send_pct;
        recv_idle_pct = recv_pct;
        set_all(16'($urandom_range(1, 20)), 16'($urandom_range(1, 10)),
                16'($urandom_range(1, 20)), 16'($urandom_range(1, 8)),
                16'($urandom_range(0, 12)));
        for (int i = 0; i < RANDOM_TICKS; i++)
        begin
            if (i == RANDOM_TICKS / 2)
            begin
                wait_idle();
                set_duration(REG_DEBOUNCE, 16'($urandom_range(0, 4)));
                set_duration(REG_BLINK, 16'($urandom_range(1, 4)));
            end
            send_tick($urandom_range(99) < 15, $urandom_range(99) < 7);
        end
    endtask

    initial
    begin
        reset_lights();
        repeat (7) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        test_power_up_debounce();
        test_directed_sequence();
        test_zero_durations();
        test_unused_registers();
        test_long_durations();
        test_random_traffic(27, 77);
        test_random_traffic(77, 27);
        test_random_traffic(0, 0);
        wait_idle();
        if (mismatches == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule

>>> files.f
+incdir+rtl/core
rtl/core/tlpe_pkg.sv
rtl/core/tlpe_regs.sv
rtl/core/tlpe_debounce.sv
rtl/core/tlpe_phase_fsm.sv
rtl/core/traffic_light_pedestrian_emergency_core.sv
tb/sv/tb.sv
